// ----- design/teq_pkg.sv -----
// ----------------------------------------------------------------------------
// Timer event queue package
// Shared widths, command and result codes, channel payload types and the
// control word broadcast to the sorted cell row.
// ----------------------------------------------------------------------------
`default_nettype none

package teq_pkg;

  // Default number of cells in the row.
  localparam int unsigned CapacityDefault = 32;

  // Fixed field widths of the channels.
  localparam int unsigned CmdW   = 2;
  localparam int unsigned KindW  = 2;
  localparam int unsigned IdW    = 32;
  localparam int unsigned TimeW  = 48;
  localparam int unsigned CountW = 6;

  // Command codes on the input channel.
  localparam logic [CmdW-1:0] CMD_SCHEDULE = 2'd0;
  localparam logic [CmdW-1:0] CMD_CANCEL   = 2'd1;
  localparam logic [CmdW-1:0] CMD_ADVANCE  = 2'd2;

  // Result kinds on the output channel.
  localparam logic [KindW-1:0] KIND_SCHED_ACK  = 2'd0;
  localparam logic [KindW-1:0] KIND_CANCEL_ACK = 2'd1;
  localparam logic [KindW-1:0] KIND_FIRED      = 2'd2;
  localparam logic [KindW-1:0] KIND_DONE       = 2'd3;

  typedef struct packed {
    logic [CmdW-1:0]  command;
    logic [IdW-1:0]   evt_id;
    logic [TimeW-1:0] time_value;
  } in_item_t;

  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [IdW-1:0]    fired_id;
    logic [TimeW-1:0]  fired_deadline;
    logic              ok;
    logic [CountW-1:0] fired_count;
    logic [CountW-1:0] pending_count;
    logic [TimeW-1:0]  next_deadline;
    logic              queue_empty;
    logic              last;
  } out_item_t;

  // Operation applied by all cells of the row together.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     dec_en;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- design/teq_cell.sv -----
// ----------------------------------------------------------------------------
// Timer event queue cell
// One slot of the sorted row. It holds an event id, its deadline and its
// rank in scheduling order, and on each cycle keeps its entry, takes the
// entry of its lower neighbour, takes the new entry, or takes the entry of
// its upper neighbour.
// ----------------------------------------------------------------------------
`default_nettype none

module teq_cell #(
  parameter int unsigned RankW = 5
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  teq_pkg::cell_ctrl_t       ctrl_i,
  input  logic [teq_pkg::IdW-1:0]   new_id_i,
  input  logic [teq_pkg::TimeW-1:0] new_dl_i,
  input  logic [RankW-1:0]          new_rank_i,
  input  logic [RankW-1:0]          del_rank_i,
  input  logic                      hit_i,
  input  logic                      seen_i,
  output logic                      seen_o,
  input  logic                      prev_valid_i,
  input  logic [teq_pkg::IdW-1:0]   prev_id_i,
  input  logic [teq_pkg::TimeW-1:0] prev_dl_i,
  input  logic [RankW-1:0]          prev_rank_i,
  input  logic                      prev_before_i,
  input  logic                      next_valid_i,
  input  logic [teq_pkg::IdW-1:0]   next_id_i,
  input  logic [teq_pkg::TimeW-1:0] next_dl_i,
  input  logic [RankW-1:0]          next_rank_i,
  output logic                      valid_o,
  output logic [teq_pkg::IdW-1:0]   id_o,
  output logic [teq_pkg::TimeW-1:0] dl_o,
  output logic [RankW-1:0]          rank_o,
  output logic                      before_o
);

  logic                      valid_q, valid_d;
  logic [teq_pkg::IdW-1:0]   id_q, id_d;
  logic [teq_pkg::TimeW-1:0] dl_q, dl_d;
  logic [RankW-1:0]          rank_q, rank_d;

  // The held entry orders ahead of the new one: earlier deadline, or the
  // same deadline and scheduled earlier.
  assign before_o = valid_q &&
                    ((dl_q < new_dl_i) || ((dl_q == new_dl_i) && (rank_q < new_rank_i)));

  // The removal point travels up the row; every cell at or above it shifts.
  assign seen_o = seen_i | hit_i;

  // Next entry of this cell.
  always_comb begin
    valid_d = valid_q;
    id_d    = id_q;
    dl_d    = dl_q;
    rank_d  = rank_q;
    unique case (ctrl_i.op)
      teq_pkg::CELL_INSERT: begin
        if (!before_o) begin
          if (prev_before_i) begin
            valid_d = 1'b1;
            id_d    = new_id_i;
            dl_d    = new_dl_i;
            rank_d  = new_rank_i;
          end else begin
            valid_d = prev_valid_i;
            id_d    = prev_id_i;
            dl_d    = prev_dl_i;
            rank_d  = prev_rank_i;
          end
        end
      end
      teq_pkg::CELL_REMOVE: begin
        if (seen_o) begin
          valid_d = next_valid_i;
          id_d    = next_id_i;
          dl_d    = next_dl_i;
          rank_d  = next_rank_i;
        end
        // Ranks above the removed one close the gap in scheduling order.
        if (ctrl_i.dec_en && (rank_d > del_rank_i)) begin
          rank_d = rank_d - RankW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q   <= id_d;
    dl_q   <= dl_d;
    rank_q <= rank_d;
  end

  assign valid_o = valid_q;
  assign id_o    = id_q;
  assign dl_o    = dl_q;
  assign rank_o  = rank_q;

endmodule

`default_nettype wire

// ----- design/timer_event_queue.sv -----
// ----------------------------------------------------------------------------
// Timer event queue
// Pending-event store kept as a row of cells sorted by deadline, ties in
// scheduling order, with schedule, cancel and advance commands.
// ----------------------------------------------------------------------------
// Usage
// Commands arrive on the input channel (in_valid_i / in_ready_o, payload
// in_data_i) and results leave on the output channel (out_valid_o /
// out_ready_i, payload out_data_o). Each command is taken on its own: the
// input is ready only while no command is in progress.
// Schedule and cancel give one result, loaded into the output register from
// the response state that follows the decide state. A schedule that moves a
// pending id to an earlier deadline passes through an insert state between
// the two. Advance gives its first item after the decide state, then one
// fired event a cycle while the output register is free, then the done
// item. The cell row does one insert or one removal per cycle, and there
// is a single output register.
// A stalled receiver holds the result in the output register and the block
// waits with it. Reset empties the row and the output register at once;
// commands are taken in the first cycle after reset is released.
// ----------------------------------------------------------------------------
`default_nettype none

module timer_event_queue #(
  parameter int unsigned CAPACITY = teq_pkg::CapacityDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  teq_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output teq_pkg::out_item_t out_data_o
);

  localparam int unsigned RankW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW   = $clog2(CAPACITY + 1);
  localparam int unsigned IdW    = teq_pkg::IdW;
  localparam int unsigned TimeW  = teq_pkg::TimeW;
  localparam int unsigned CountW = teq_pkg::CountW;
  localparam logic [TimeW-1:0] NoDeadline = '1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_INSERT,
    ST_RESP,
    ST_FIRE
  } state_e;

  state_e                     state_q, state_d;
  logic [teq_pkg::CmdW-1:0]   cmd_q, cmd_d;
  logic [IdW-1:0]             id_q, id_d;
  logic [TimeW-1:0]           tv_q, tv_d;
  logic [RankW-1:0]           rank_q, rank_d;
  logic [teq_pkg::KindW-1:0]  kind_q, kind_d;
  logic [TimeW-1:0]           rdl_q, rdl_d;
  logic                       ok_q, ok_d;
  logic [CntW-1:0]            pending_q, pending_d;
  logic [CntW-1:0]            fc_q, fc_d;
  logic                       out_valid_q, out_valid_d;
  teq_pkg::out_item_t         out_q, out_d;

  // Cell row
  teq_pkg::cell_ctrl_t  ctrl;
  logic [CAPACITY-1:0]  hit;
  logic [CAPACITY:0]    seen;
  logic [CAPACITY-1:0]  c_valid;
  logic [CAPACITY-1:0]  c_before;
  logic [IdW-1:0]       c_id   [CAPACITY];
  logic [TimeW-1:0]     c_dl   [CAPACITY];
  logic [RankW-1:0]     c_rank [CAPACITY];
  logic [RankW-1:0]     ins_rank;
  logic [RankW-1:0]     del_rank;

  // Lookup of the command's id
  logic [CAPACITY-1:0]  match;
  logic                 any_match;
  logic [TimeW-1:0]     sel_dl;
  logic [RankW-1:0]     sel_rank;

  logic                 out_free;
  logic                 due;
  logic [TimeW-1:0]     next_dl_now;

  assign seen[0] = 1'b0;

  // A new entry takes the rank after all pending ones; a moved entry keeps its rank.
  assign ins_rank = (state_q == ST_INSERT) ? rank_q : RankW'(pending_q);
  assign del_rank = (state_q == ST_FIRE) ? c_rank[0] : sel_rank;

  // Row of cells, each wired to both neighbours.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic             p_valid, p_before, n_valid;
    logic [IdW-1:0]   p_id, n_id;
    logic [TimeW-1:0] p_dl, n_dl;
    logic [RankW-1:0] p_rank, n_rank;

    // Below the first cell everything orders ahead of a new entry.
    if (i == 0) begin : g_first
      assign p_valid  = 1'b0;
      assign p_before = 1'b1;
      assign p_id     = '0;
      assign p_dl     = '0;
      assign p_rank   = '0;
    end else begin : g_lower
      assign p_valid  = c_valid[i-1];
      assign p_before = c_before[i-1];
      assign p_id     = c_id[i-1];
      assign p_dl     = c_dl[i-1];
      assign p_rank   = c_rank[i-1];
    end

    if (i == CAPACITY - 1) begin : g_top
      assign n_valid = 1'b0;
      assign n_id    = '0;
      assign n_dl    = '0;
      assign n_rank  = '0;
    end else begin : g_upper
      assign n_valid = c_valid[i+1];
      assign n_id    = c_id[i+1];
      assign n_dl    = c_dl[i+1];
      assign n_rank  = c_rank[i+1];
    end

    teq_cell #(
      .RankW(RankW)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .new_id_i     (id_q),
      .new_dl_i     (tv_q),
      .new_rank_i   (ins_rank),
      .del_rank_i   (del_rank),
      .hit_i        (hit[i]),
      .seen_i       (seen[i]),
      .seen_o       (seen[i+1]),
      .prev_valid_i (p_valid),
      .prev_id_i    (p_id),
      .prev_dl_i    (p_dl),
      .prev_rank_i  (p_rank),
      .prev_before_i(p_before),
      .next_valid_i (n_valid),
      .next_id_i    (n_id),
      .next_dl_i    (n_dl),
      .next_rank_i  (n_rank),
      .valid_o      (c_valid[i]),
      .id_o         (c_id[i]),
      .dl_o         (c_dl[i]),
      .rank_o       (c_rank[i]),
      .before_o     (c_before[i])
    );

    assign match[i] = c_valid[i] && (c_id[i] == id_q);
  end

  // Deadline and rank of the matching cell; ids are unique so at most one hits.
  always_comb begin
    sel_dl   = '0;
    sel_rank = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      sel_dl   = sel_dl | (match[i] ? c_dl[i] : '0);
      sel_rank = sel_rank | (match[i] ? c_rank[i] : '0);
    end
  end

  assign any_match   = |match;
  assign out_free    = !out_valid_q || out_ready_i;
  assign due         = c_valid[0] && (c_dl[0] <= tv_q);
  assign next_dl_now = c_valid[0] ? c_dl[0] : NoDeadline;

  // Command sequencing and result formation.
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    id_d        = id_q;
    tv_d        = tv_q;
    rank_d      = rank_q;
    kind_d      = kind_q;
    rdl_d       = rdl_q;
    ok_d        = ok_q;
    pending_d   = pending_q;
    fc_d        = fc_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    ctrl        = '{op: teq_pkg::CELL_HOLD, dec_en: 1'b0};
    hit         = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_d   = in_data_i.command;
          id_d    = in_data_i.evt_id;
          tv_d    = in_data_i.time_value;
          state_d = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        state_d = ST_RESP;
        rdl_d   = '0;
        ok_d    = 1'b0;
        case (cmd_q)
          teq_pkg::CMD_SCHEDULE: begin
            kind_d = teq_pkg::KIND_SCHED_ACK;
            if (any_match) begin
              ok_d = 1'b1;
              if (tv_q < sel_dl) begin
                // Lift the entry out now and put it back at its new place next cycle.
                hit        = match;
                ctrl.op    = teq_pkg::CELL_REMOVE;
                rank_d     = sel_rank;
                rdl_d      = tv_q;
                state_d    = ST_INSERT;
              end else begin
                rdl_d = sel_dl;
              end
            end else if (pending_q != CntW'(CAPACITY)) begin
              ctrl.op   = teq_pkg::CELL_INSERT;
              pending_d = pending_q + CntW'(1);
              ok_d      = 1'b1;
              rdl_d     = tv_q;
            end
          end
          teq_pkg::CMD_CANCEL: begin
            kind_d = teq_pkg::KIND_CANCEL_ACK;
            if (any_match) begin
              hit         = match;
              ctrl.op     = teq_pkg::CELL_REMOVE;
              ctrl.dec_en = 1'b1;
              pending_d   = pending_q - CntW'(1);
              ok_d        = 1'b1;
            end
          end
          teq_pkg::CMD_ADVANCE: begin
            fc_d    = '0;
            state_d = ST_FIRE;
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end

      ST_INSERT: begin
        ctrl.op = teq_pkg::CELL_INSERT;
        state_d = ST_RESP;
      end

      ST_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d = '{
            kind:           kind_q,
            fired_id:       id_q,
            fired_deadline: rdl_q,
            ok:             ok_q,
            fired_count:    '0,
            pending_count:  CountW'(pending_q),
            next_deadline:  next_dl_now,
            queue_empty:    (pending_q == '0),
            last:           1'b1
          };
          state_d = ST_IDLE;
        end
      end

      ST_FIRE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (due) begin
            // The head of the row is the earliest event; pop it.
            hit         = CAPACITY'(1);
            ctrl.op     = teq_pkg::CELL_REMOVE;
            ctrl.dec_en = 1'b1;
            pending_d   = pending_q - CntW'(1);
            fc_d        = fc_q + CntW'(1);
            out_d = '{
              kind:           teq_pkg::KIND_FIRED,
              fired_id:       c_id[0],
              fired_deadline: c_dl[0],
              ok:             1'b1,
              fired_count:    '0,
              pending_count:  CountW'(pending_q - CntW'(1)),
              next_deadline:  c_valid[1] ? c_dl[1] : NoDeadline,
              queue_empty:    (pending_q == CntW'(1)),
              last:           1'b0
            };
          end else begin
            out_d = '{
              kind:           teq_pkg::KIND_DONE,
              fired_id:       '0,
              fired_deadline: '0,
              ok:             1'b1,
              fired_count:    CountW'(fc_q),
              pending_count:  CountW'(pending_q),
              next_deadline:  next_dl_now,
              queue_empty:    (pending_q == '0),
              last:           1'b1
            };
            state_d = ST_IDLE;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cmd_q       <= '0;
      id_q        <= '0;
      tv_q        <= '0;
      rank_q      <= '0;
      kind_q      <= '0;
      rdl_q       <= '0;
      ok_q        <= 1'b0;
      pending_q   <= '0;
      fc_q        <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      cmd_q       <= cmd_d;
      id_q        <= id_d;
      tv_q        <= tv_d;
      rank_q      <= rank_d;
      kind_q      <= kind_d;
      rdl_q       <= rdl_d;
      ok_q        <= ok_d;
      pending_q   <= pending_d;
      fc_q        <= fc_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // The pending count never passes the number of cells.
  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= CntW'(CAPACITY))
    else $error("pending count exceeds the capacity");

  // The occupied cells and the pending count agree; a moved entry is out of
  // the row during the insert state that puts it back.
  a_valid_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(c_valid) == (int'(pending_q) - ((state_q == ST_INSERT) ? 1 : 0)))
    else $error("occupied cells disagree with the pending count");

  // The head of the row is never later than its neighbour.
  a_head_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_valid[1] |-> (c_valid[0] && (c_dl[0] <= c_dl[1])))
    else $error("cell row is out of deadline order at its head");
`endif

endmodule

`default_nettype wire

// ----- test/teq_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Timer event queue checker
// Watches both channels of the queue. Every accepted command updates a
// private copy of the pending-event store and queues the results it should
// cause. Every accepted result is compared field by field with the oldest
// queued expectation. The mismatch count and the number of results still
// awaited are handed to the testbench top.
// ----------------------------------------------------------------------------

module teq_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  teq_pkg::in_item_t  in_data_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  teq_pkg::out_item_t out_data_i,
  output int                 fail_count_o,
  output int                 outstanding_o
);

  localparam int unsigned Cap    = teq_pkg::CapacityDefault;
  localparam int unsigned IdW    = teq_pkg::IdW;
  localparam int unsigned TimeW  = teq_pkg::TimeW;
  localparam int unsigned KindW  = teq_pkg::KindW;
  localparam int unsigned CountW = teq_pkg::CountW;

  // Private copy of the store: pending entries packed in scheduling order.
  logic [TimeW-1:0] slot_deadline [Cap];
  logic [IdW-1:0]   slot_id       [Cap];
  int unsigned      live_count = 0;
  logic [TimeW-1:0] time_now   = '0;

  teq_pkg::out_item_t awaited_q[$];
  int                 fails = 0;

  initial outstanding_o = 0;
  assign fail_count_o = fails;

  // One printed line per mismatch.
  task automatic report(input string msg);
    fails++;
    $display("[%0t] checker: %s", $time, msg);
  endtask

  function automatic int locate(input logic [IdW-1:0] id);
    for (int i = 0; i < live_count; i++) begin
      if (slot_id[i] == id) return i;
    end
    return -1;
  endfunction

  // Remove one entry and close the gap, keeping scheduling order.
  function automatic void drop_slot(input int pos);
    for (int i = pos; i + 1 < live_count; i++) begin
      slot_id[i]       = slot_id[i + 1];
      slot_deadline[i] = slot_deadline[i + 1];
    end
    live_count--;
  endfunction

  // Earliest deadline; the lowest slot wins a tie.
  function automatic int soonest();
    int best;
    best = -1;
    for (int i = 0; i < live_count; i++) begin
      if (best < 0 || slot_deadline[i] < slot_deadline[best]) best = i;
    end
    return best;
  endfunction

  // Build a result with the store status as it now stands.
  function automatic teq_pkg::out_item_t status_item(input logic [KindW-1:0] kind,
                                                     input logic [IdW-1:0] id,
                                                     input logic [TimeW-1:0] dl,
                                                     input logic ok,
                                                     input logic [CountW-1:0] fc,
                                                     input logic last);
    teq_pkg::out_item_t r;
    int                 b;
    b = soonest();
    r.kind           = kind;
    r.fired_id       = id;
    r.fired_deadline = dl;
    r.ok             = ok;
    r.fired_count    = fc;
    r.pending_count  = CountW'(live_count);
    r.next_deadline  = (b < 0) ? '1 : slot_deadline[b];
    r.queue_empty    = (live_count == 0);
    r.last           = last;
    return r;
  endfunction

  // Apply one command to the private store and queue its results.
  task automatic predict(input teq_pkg::in_item_t cmd);
    int                pos;
    int                b;
    int unsigned       fired;
    logic [IdW-1:0]    fid;
    logic [TimeW-1:0]  fdl;
    pos = locate(cmd.evt_id);
    case (cmd.command)
      teq_pkg::CMD_SCHEDULE: begin
        if (pos >= 0) begin
          // Already pending: the earlier deadline stays, the slot stays.
          if (cmd.time_value < slot_deadline[pos]) slot_deadline[pos] = cmd.time_value;
          awaited_q.push_back(status_item(teq_pkg::KIND_SCHED_ACK, cmd.evt_id,
                                          slot_deadline[pos], 1'b1, '0, 1'b1));
        end else if (live_count < Cap) begin
          slot_id[live_count]       = cmd.evt_id;
          slot_deadline[live_count] = cmd.time_value;
          live_count++;
          awaited_q.push_back(status_item(teq_pkg::KIND_SCHED_ACK, cmd.evt_id,
                                          cmd.time_value, 1'b1, '0, 1'b1));
        end else begin
          awaited_q.push_back(status_item(teq_pkg::KIND_SCHED_ACK, cmd.evt_id,
                                          '0, 1'b0, '0, 1'b1));
        end
      end
      teq_pkg::CMD_CANCEL: begin
        if (pos >= 0) drop_slot(pos);
        awaited_q.push_back(status_item(teq_pkg::KIND_CANCEL_ACK, cmd.evt_id,
                                        '0, pos >= 0, '0, 1'b1));
      end
      teq_pkg::CMD_ADVANCE: begin
        time_now = cmd.time_value;
        fired    = 0;
        // Fire everything due, earliest first, then close with the count.
        while (1) begin
          b = soonest();
          if (b < 0 || slot_deadline[b] > time_now) break;
          fid = slot_id[b];
          fdl = slot_deadline[b];
          drop_slot(b);
          awaited_q.push_back(status_item(teq_pkg::KIND_FIRED, fid, fdl, 1'b1,
                                          '0, 1'b0));
          fired++;
        end
        awaited_q.push_back(status_item(teq_pkg::KIND_DONE, '0, '0, 1'b1,
                                        CountW'(fired), 1'b1));
      end
      default: begin
        // The unused command code is ignored and gives no result.
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) begin
      report($sformatf("%s is %0h, expected %0h", name, got, want));
    end
  endtask

  task automatic compare_result(input teq_pkg::out_item_t got,
                                input teq_pkg::out_item_t want);
    check_field("kind", 64'(got.kind), 64'(want.kind));
    check_field("fired_id", 64'(got.fired_id), 64'(want.fired_id));
    check_field("fired_deadline", 64'(got.fired_deadline), 64'(want.fired_deadline));
    check_field("ok", 64'(got.ok), 64'(want.ok));
    check_field("fired_count", 64'(got.fired_count), 64'(want.fired_count));
    check_field("pending_count", 64'(got.pending_count), 64'(want.pending_count));
    check_field("next_deadline", 64'(got.next_deadline), 64'(want.next_deadline));
    check_field("queue_empty", 64'(got.queue_empty), 64'(want.queue_empty));
    check_field("last", 64'(got.last), 64'(want.last));
  endtask

  // Results are matched before the command of the same edge is applied, as
  // no result can leave in the cycle of its own command transfer.
  always @(posedge clk_i) begin
    teq_pkg::out_item_t want;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (awaited_q.size() == 0) begin
          report($sformatf("result transfer of kind %0d with nothing awaited",
                           out_data_i.kind));
        end else begin
          want = awaited_q.pop_front();
          compare_result(out_data_i, want);
        end
      end
      if (in_valid_i && in_ready_i) predict(in_data_i);
    end
    outstanding_o <= awaited_q.size();
  end

endmodule

// ----- test/tb_timer_event_queue.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Timer event queue testbench
// Drives schedule, cancel and advance commands into the queue: a directed
// opening over the corner cases, then random phases of schedule bursts,
// cancels, advances and noise, with random idling on both channels, a long
// receiver hold-off and a full drain in the middle. The checker beside the
// block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------

module tb_timer_event_queue;

  localparam int unsigned CmdW  = teq_pkg::CmdW;
  localparam int unsigned IdW   = teq_pkg::IdW;
  localparam int unsigned TimeW = teq_pkg::TimeW;

  localparam logic [CmdW-1:0] CmdUnused = 2'd3;
  localparam int unsigned     PoolSize  = 48;
  localparam int unsigned     RandItems = 300;
  localparam int unsigned     CycleLimit = 300000;
  localparam int unsigned     HoldCycles = 400;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  teq_pkg::in_item_t  in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  teq_pkg::out_item_t out_data;

  int          fail_count;
  int          outstanding;
  int unsigned cycles     = 0;
  int unsigned hold_req   = 0;
  int unsigned hold_seen  = 0;
  int unsigned hold_left  = 0;
  logic        calm       = 1'b0;

  logic [TimeW-1:0] stim_now = '0;
  logic [IdW-1:0]   id_pool [PoolSize];
  int unsigned      rand_sent = 0;

  timer_event_queue uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  teq_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .outstanding_o(outstanding)
  );

  // Clock: 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver: random stalls, a long hold-off on request, none while calm.
  always @(posedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HoldCycles;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 28);
    end
  end

  // Offer one command, with a random gap first, and wait for its transfer.
  task automatic send(input logic [CmdW-1:0] cmd, input logic [IdW-1:0] id,
                      input logic [TimeW-1:0] tv);
    teq_pkg::in_item_t item;
    item.command    = cmd;
    item.evt_id     = id;
    item.time_value = tv;
    while (!calm && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    if (cmd == teq_pkg::CMD_ADVANCE) stim_now = tv;
    if (cmd != CmdUnused) rand_sent++;
  endtask

  // Stop offering until every awaited result has been taken.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  function automatic logic [TimeW-1:0] rand_time();
    return TimeW'({$urandom(), $urandom()});
  endfunction

  // Mostly ids from a small pool so that hits, cancels and a full store occur.
  function automatic logic [IdW-1:0] pick_id();
    if ($urandom_range(99) < 90) return id_pool[$urandom_range(PoolSize - 1)];
    return $urandom();
  endfunction

  // Deadlines mostly close to the current time, some already past.
  function automatic logic [TimeW-1:0] pick_deadline();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return rand_time();
    if (r < 11) return '1;
    if (r < 14) return '0;
    return stim_now + TimeW'($urandom_range(2500)) - TimeW'($urandom_range(200));
  endfunction

  function automatic logic [TimeW-1:0] pick_advance();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) return rand_time();
    if (r < 8) return stim_now - TimeW'($urandom_range(1000));
    return stim_now + TimeW'($urandom_range(1500));
  endfunction

  initial begin
    int unsigned sel;
    int unsigned n;
    logic        hold_done;
    logic        drain_done;
    hold_done  = 1'b0;
    drain_done = 1'b0;
    id_pool[0] = '0;
    id_pool[1] = '1;
    for (int k = 2; k < PoolSize; k++) id_pool[k] = $urandom();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening: empty store, extremes, repeats, ties, time going back.
    send(teq_pkg::CMD_ADVANCE, '0, '0);
    send(teq_pkg::CMD_CANCEL, '0, '0);
    send(teq_pkg::CMD_SCHEDULE, '0, '0);
    send(teq_pkg::CMD_SCHEDULE, '1, '1);
    send(teq_pkg::CMD_SCHEDULE, 32'd5, 48'd100);
    send(teq_pkg::CMD_SCHEDULE, 32'd5, 48'd200);
    send(teq_pkg::CMD_SCHEDULE, 32'd5, 48'd50);
    send(teq_pkg::CMD_SCHEDULE, 32'd6, 48'd50);
    send(CmdUnused, '1, '1);
    send(teq_pkg::CMD_CANCEL, '1, '0);
    send(teq_pkg::CMD_CANCEL, '1, '0);
    send(teq_pkg::CMD_ADVANCE, '0, 48'd60);
    send(teq_pkg::CMD_SCHEDULE, 32'd7, 48'd1000);
    send(teq_pkg::CMD_SCHEDULE, 32'hAAAA_5555, 48'h5555_AAAA_5555);
    send(teq_pkg::CMD_ADVANCE, '1, 48'd10);
    send(teq_pkg::CMD_SCHEDULE, 32'h5555_AAAA, 48'd5);
    send(teq_pkg::CMD_ADVANCE, '0, '1);
    send(teq_pkg::CMD_ADVANCE, '0, '0);
    rand_sent = 0;

    // Fill the store beyond its size, then hit a pending id while full.
    for (int k = 0; k < 36; k++) send(teq_pkg::CMD_SCHEDULE, id_pool[k], pick_deadline());
    send(teq_pkg::CMD_SCHEDULE, id_pool[2], pick_deadline());

    // Random phases.
    while (rand_sent < RandItems) begin
      if (!hold_done && rand_sent >= 80) begin
        hold_done = 1'b1;
        hold_req <= hold_req + 1;
      end
      if (!drain_done && rand_sent >= 150) begin
        drain_done = 1'b1;
        wait_drained();
      end
      calm <= (rand_sent >= 180 && rand_sent < 240);
      sel = $urandom_range(99);
      if (sel < 35) begin
        n = $urandom_range(36, 3);
        repeat (n) send(teq_pkg::CMD_SCHEDULE, pick_id(), pick_deadline());
      end else if (sel < 58) begin
        n = $urandom_range(6, 1);
        repeat (n) send(teq_pkg::CMD_CANCEL, pick_id(), '0);
      end else if (sel < 88) begin
        send(teq_pkg::CMD_ADVANCE, $urandom(), pick_advance());
      end else begin
        // Noise: any command code with fully random fields.
        n = $urandom_range(4, 1);
        repeat (n) send(CmdW'($urandom_range(3)), $urandom(), rand_time());
      end
    end

    wait_drained();
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- timer_event_queue.f -----
design/teq_pkg.sv
design/teq_cell.sv
design/timer_event_queue.sv
test/teq_checker.sv
test/tb_timer_event_queue.sv
